### rtl/core/urtb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urtb_pkg
// Shared types and constants for the UART receive/transmit ring buffers.
// ----------------------------------------------------------------------------
package urtb_pkg;

  localparam int URTB_RX_DEPTH_DEF = 64;
  localparam int URTB_TX_DEPTH_DEF = 64;

  localparam int OP_W   = 3;
  localparam int BYTE_W = 8;
  localparam int CNT_W  = 6;

  // Operation codes carried in the command payload
  localparam logic [OP_W-1:0] OP_LINE_RX  = 3'd0;
  localparam logic [OP_W-1:0] OP_READ     = 3'd1;
  localparam logic [OP_W-1:0] OP_PEEK     = 3'd2;
  localparam logic [OP_W-1:0] OP_HOST_WR  = 3'd3;
  localparam logic [OP_W-1:0] OP_DRE_EVT  = 3'd4;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [BYTE_W-1:0] data_byte;
    logic              parity_error;
    logic              data_reg_empty;
  } cmd_t;

  typedef struct packed {
    logic [BYTE_W-1:0] read_byte;
    logic              read_valid;
    logic              send_valid;
    logic [BYTE_W-1:0] send_byte;
    logic              accepted;
    logic [CNT_W-1:0]  rx_count;
    logic [CNT_W-1:0]  tx_free;
    logic              drain_on;
  } rsp_t;

endpackage

### rtl/core/urtb_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urtb_stream_if
// Valid/ready channel with a typed payload; source drives, sink takes.
// ----------------------------------------------------------------------------
interface urtb_stream_if #(
  parameter type payload_t = logic
);

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

### rtl/core/urtb_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urtb_ram
// Generic single-clock RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module urtb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/uart_rx_tx_ring_buffers_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_rx_tx_ring_buffers_top
// Receive and transmit byte rings for a UART, each in its own RAM.
// ----------------------------------------------------------------------------
//
//   channel  dir  payload  transfer when
//   -------  ---  -------  ----------------------------
//   cmd      in   cmd_t    cmd.valid && cmd.ready
//   rsp      out  rsp_t    rsp.valid && rsp.ready
//
// A command's result is registered in the output register. A read or peek
// that finds a byte and a drain event that finds a queued byte first wait in
// S_READ for the registered read of the ring RAM holding the byte at the tail.
// Reset clears the four ring pointers and the drain flag; the RAMs are not
// cleared, since every entry is written before it is read.
// cmd.ready drops while a RAM read is in flight or while a result sits in
// the output register and rsp.ready is low.
// ----------------------------------------------------------------------------
module uart_rx_tx_ring_buffers_top import urtb_pkg::*; #(
  parameter int RX_DEPTH = URTB_RX_DEPTH_DEF,
  parameter int TX_DEPTH = URTB_TX_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  urtb_stream_if.sink   cmd,
  urtb_stream_if.source rsp
);

  localparam int RX_PW = $clog2(RX_DEPTH);
  localparam int TX_PW = $clog2(TX_DEPTH);
  // Occupancy width: wide enough for the depth itself and for the status field
  localparam int RX_UW = (RX_PW + 1 > CNT_W) ? RX_PW + 1 : CNT_W;
  localparam int TX_UW = (TX_PW + 1 > CNT_W) ? TX_PW + 1 : CNT_W;
  localparam logic [RX_PW-1:0] RX_LAST = RX_PW'(RX_DEPTH - 1);
  localparam logic [TX_PW-1:0] TX_LAST = TX_PW'(TX_DEPTH - 1);

  typedef enum logic [0:0] {
    S_IDLE,
    S_READ
  } state_t;

  state_t state;

  // Ring pointers: head is the next write slot, tail the oldest byte
  logic [RX_PW-1:0] rx_head, rx_tail, rx_head_next, rx_tail_next;
  logic [TX_PW-1:0] tx_head, tx_tail, tx_head_next, tx_tail_next;
  logic [RX_PW-1:0] rx_head_inc, rx_tail_inc;
  logic [TX_PW-1:0] tx_head_inc, tx_tail_inc;
  logic             drain_enable, drain_enable_next;

  // Output register and the partial result held while the RAM read is out
  logic  out_valid;
  rsp_t  out_item;
  rsp_t  pend;
  logic  pend_rx;
  rsp_t  item;
  rsp_t  merged;

  logic             accept;
  logic             rx_we, rx_re, tx_we, tx_re;
  logic [BYTE_W-1:0] rx_q, tx_q;
  logic             rx_empty, tx_empty;
  logic [RX_UW-1:0] rx_used;
  logic [TX_UW-1:0] tx_used;
  logic [TX_UW-1:0] tx_free_w;

  cmd_t c;
  assign c = cmd.payload;

  // Take a command only when idle and the output register can take its result
  assign cmd.ready = (state == S_IDLE) && (!out_valid || rsp.ready);
  assign accept    = cmd.valid && cmd.ready;

  assign rsp.valid   = out_valid;
  assign rsp.payload = out_item;

  assign rx_head_inc = (rx_head == RX_LAST) ? '0 : rx_head + 1'b1;
  assign rx_tail_inc = (rx_tail == RX_LAST) ? '0 : rx_tail + 1'b1;
  assign tx_head_inc = (tx_head == TX_LAST) ? '0 : tx_head + 1'b1;
  assign tx_tail_inc = (tx_tail == TX_LAST) ? '0 : tx_tail + 1'b1;
  assign rx_empty    = (rx_head == rx_tail);
  assign tx_empty    = (tx_head == tx_tail);

  // Decode the command against the current pointers
  always_comb begin
    rx_head_next      = rx_head;
    rx_tail_next      = rx_tail;
    tx_head_next      = tx_head;
    tx_tail_next      = tx_tail;
    drain_enable_next = drain_enable;
    rx_we             = 1'b0;
    rx_re             = 1'b0;
    tx_we             = 1'b0;
    tx_re             = 1'b0;
    item              = '0;
    case (c.operation)
      OP_LINE_RX: begin
        // Drop bytes with bad parity or arriving at a full ring
        if (!c.parity_error && (rx_head_inc != rx_tail)) begin
          rx_we         = accept;
          rx_head_next  = rx_head_inc;
          item.accepted = 1'b1;
        end
      end
      OP_READ, OP_PEEK: begin
        if (!rx_empty) begin
          rx_re           = accept;
          item.read_valid = 1'b1;
          if (c.operation == OP_READ) begin
            rx_tail_next = rx_tail_inc;
          end
        end
      end
      OP_HOST_WR: begin
        if (tx_empty && c.data_reg_empty) begin
          // Bypass the ring: hand the byte straight to the data register
          item.send_valid = 1'b1;
          item.send_byte  = c.data_byte;
          item.accepted   = 1'b1;
        end else if (tx_head_inc != tx_tail) begin
          tx_we             = accept;
          tx_head_next      = tx_head_inc;
          drain_enable_next = 1'b1;
          item.accepted     = 1'b1;
        end
      end
      OP_DRE_EVT: begin
        if (!tx_empty) begin
          tx_re             = accept;
          item.send_valid   = 1'b1;
          tx_tail_next      = tx_tail_inc;
          drain_enable_next = (tx_head != tx_tail_inc);
        end else begin
          drain_enable_next = 1'b0;
        end
      end
      default: begin
      end
    endcase

    rx_used = (rx_head_next >= rx_tail_next)
            ? RX_UW'(rx_head_next) - RX_UW'(rx_tail_next)
            : RX_UW'(RX_DEPTH) - RX_UW'(rx_tail_next) + RX_UW'(rx_head_next);
    tx_used = (tx_head_next >= tx_tail_next)
            ? TX_UW'(tx_head_next) - TX_UW'(tx_tail_next)
            : TX_UW'(TX_DEPTH) - TX_UW'(tx_tail_next) + TX_UW'(tx_head_next);
    tx_free_w = TX_UW'(TX_DEPTH - 1) - tx_used;

    item.rx_count = rx_used[CNT_W-1:0];
    item.tx_free  = tx_free_w[CNT_W-1:0];
    item.drain_on = drain_enable_next;
  end

  // Fill in the byte that the RAM returned for a pending read or drain
  always_comb begin
    merged = pend;
    if (pend_rx) begin
      merged.read_byte = rx_q;
    end else begin
      merged.send_byte = tx_q;
    end
  end

  urtb_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (RX_DEPTH)
  ) u_rx_ram (
    .clk   (clk),
    .we    (rx_we),
    .waddr (rx_head),
    .wdata (c.data_byte),
    .re    (rx_re),
    .raddr (rx_tail),
    .rdata (rx_q)
  );

  urtb_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (TX_DEPTH)
  ) u_tx_ram (
    .clk   (clk),
    .we    (tx_we),
    .waddr (tx_head),
    .wdata (c.data_byte),
    .re    (tx_re),
    .raddr (tx_tail),
    .rdata (tx_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      rx_head      <= '0;
      rx_tail      <= '0;
      tx_head      <= '0;
      tx_tail      <= '0;
      drain_enable <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            rx_head      <= rx_head_next;
            rx_tail      <= rx_tail_next;
            tx_head      <= tx_head_next;
            tx_tail      <= tx_tail_next;
            drain_enable <= drain_enable_next;
            if (rx_re || tx_re) begin
              // Hold the status until the RAM byte arrives; the output
              // register is empty or transfers its result at this edge
              pend      <= item;
              pend_rx   <= rx_re;
              out_valid <= 1'b0;
              state     <= S_READ;
            end else begin
              out_item  <= item;
              out_valid <= 1'b1;
            end
          end else if (rsp.ready) begin
            // Release the output register once its result transfers
            out_valid <= 1'b0;
          end
        end
        S_READ: begin
          out_item  <= merged;
          out_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  // A read in flight always finds the output register empty
  a_read_slot_free: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> !out_valid)
    else $error("RAM read completed into an occupied output register");

  // Draining is on exactly while the transmit ring holds bytes
  a_drain_matches_ring: assert property (@(posedge clk) disable iff (rst)
    drain_enable == (tx_head != tx_tail))
    else $error("drain flag disagrees with transmit ring occupancy");

  // Every accepted command yields a result now or after the RAM read
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    accept |=> (out_valid || (state == S_READ)))
    else $error("accepted command produced no result");

  // A result never reports a received and a sent byte together
  a_one_byte_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_item.read_valid && out_item.send_valid))
    else $error("result carries both read and send bytes");

  // Pointers stay inside their rings for any depth
  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    (rx_head <= RX_LAST) && (rx_tail <= RX_LAST) &&
    (tx_head <= TX_LAST) && (tx_tail <= TX_LAST))
    else $error("ring pointer beyond ring depth");
`endif

endmodule

### dv/urtb_ring_sb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urtb_ring_sb_pkg
// Shadow copy of the UART receive/transmit rings and the response checker.
// ----------------------------------------------------------------------------
package urtb_ring_sb_pkg;

  import urtb_pkg::*;

  localparam int RING_RX_DEPTH = URTB_RX_DEPTH_DEF;
  localparam int RING_TX_DEPTH = URTB_TX_DEPTH_DEF;

  // Codes with no operation behind them; the block reports status only
  localparam logic [OP_W-1:0] OP_UNUSED_FIRST = 3'd5;
  localparam logic [OP_W-1:0] OP_UNUSED_LAST  = 3'd7;

  class uart_ring_scoreboard;

    logic [BYTE_W-1:0] rx_ring [RING_RX_DEPTH];
    logic [BYTE_W-1:0] tx_ring [RING_TX_DEPTH];
    int                rx_wr;
    int                rx_rd;
    int                tx_wr;
    int                tx_rd;
    bit                drain_armed;
    rsp_t              pending_rsp [$];
    int                errors;

    function new();
      rx_wr       = 0;
      rx_rd       = 0;
      tx_wr       = 0;
      tx_rd       = 0;
      drain_armed = 1'b0;
      errors      = 0;
    endfunction

    function int pending();
      return pending_rsp.size();
    endfunction

    static function int wrap_next(int idx, int depth);
      return (idx + 1 >= depth) ? 0 : idx + 1;
    endfunction

    static function int occupancy(int wr, int rd, int depth);
      return (wr >= rd) ? wr - rd : depth - rd + wr;
    endfunction

    // Advance the shadow rings by one command and queue the response it yields.
    function void note_command(cmd_t c);
      rsp_t r;
      int   nxt;
      r = '0;
      case (c.operation)
        OP_LINE_RX: begin
          nxt = wrap_next(rx_wr, RING_RX_DEPTH);
          if (!c.parity_error && nxt != rx_rd) begin
            rx_ring[rx_wr] = c.data_byte;
            rx_wr          = nxt;
            r.accepted     = 1'b1;
          end
        end
        OP_READ, OP_PEEK: begin
          if (rx_wr != rx_rd) begin
            r.read_byte  = rx_ring[rx_rd];
            r.read_valid = 1'b1;
            if (c.operation == OP_READ) rx_rd = wrap_next(rx_rd, RING_RX_DEPTH);
          end
        end
        OP_HOST_WR: begin
          nxt = wrap_next(tx_wr, RING_TX_DEPTH);
          if (tx_wr == tx_rd && c.data_reg_empty) begin
            r.send_valid = 1'b1;
            r.send_byte  = c.data_byte;
            r.accepted   = 1'b1;
          end else if (nxt != tx_rd) begin
            tx_ring[tx_wr] = c.data_byte;
            tx_wr          = nxt;
            drain_armed    = 1'b1;
            r.accepted     = 1'b1;
          end
        end
        OP_DRE_EVT: begin
          if (tx_wr != tx_rd) begin
            r.send_valid = 1'b1;
            r.send_byte  = tx_ring[tx_rd];
            tx_rd        = wrap_next(tx_rd, RING_TX_DEPTH);
          end
          if (tx_wr == tx_rd) drain_armed = 1'b0;
        end
        default: ;
      endcase
      r.rx_count = CNT_W'(occupancy(rx_wr, rx_rd, RING_RX_DEPTH));
      r.tx_free  = CNT_W'(RING_TX_DEPTH - 1 - occupancy(tx_wr, tx_rd, RING_TX_DEPTH));
      r.drain_on = drain_armed;
      pending_rsp.push_back(r);
    endfunction

    function void check_field(string field, logic [BYTE_W-1:0] want, logic [BYTE_W-1:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_response(rsp_t got);
      rsp_t want;
      if (pending_rsp.size() == 0) begin
        $display("%0t: response 0x%0h arrived with no command outstanding", $time, got);
        errors++;
        return;
      end
      want = pending_rsp.pop_front();
      check_field("read_byte",  want.read_byte,  got.read_byte);
      check_field("read_valid", want.read_valid, got.read_valid);
      check_field("send_valid", want.send_valid, got.send_valid);
      check_field("send_byte",  want.send_byte,  got.send_byte);
      check_field("accepted",   want.accepted,   got.accepted);
      check_field("rx_count",   want.rx_count,   got.rx_count);
      check_field("tx_free",    want.tx_free,    got.tx_free);
      check_field("drain_on",   want.drain_on,   got.drain_on);
    endfunction

  endclass

endpackage

### dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives commands into the UART ring buffer block and checks every response
// against a shadow copy of both rings. A short directed sequence covers empty
// rings, dropped bytes, direct sends and draining; random traffic then swings
// both rings between full and empty under random stalls on both channels.
// ----------------------------------------------------------------------------
module testbench import urtb_pkg::*, urtb_ring_sb_pkg::*;;

  typedef enum int {MIX_TRAFFIC, FILL_RINGS, DRAIN_RINGS} traffic_mode_t;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int RANDOM_ITEMS  = 1900;
  // Traffic mode and sender idling change every segment of this many items
  localparam int SEGMENT_ITEMS = 100;
  // Receiver holds off this long once it has taken HOLD_AFTER responses
  localparam int HOLD_AFTER    = 400;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 8;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  int unsigned cycle_count   = 0;
  int unsigned items_sent    = 0;
  int unsigned results_taken = 0;

  uart_ring_scoreboard sb;

  urtb_stream_if #(.payload_t(cmd_t)) cmd_ch ();
  urtb_stream_if #(.payload_t(rsp_t)) rsp_ch ();

  uart_rx_tx_ring_buffers_top #(
    .RX_DEPTH(RING_RX_DEPTH),
    .TX_DEPTH(RING_TX_DEPTH)
  ) uut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_ch),
    .rsp(rsp_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Sample both channels at the rising edge. A command is noted before a
  // response is checked, though no response can follow its own command in
  // the same cycle anyway.
  always @(posedge clk) begin
    if (!rst) begin
      if (cmd_ch.valid && cmd_ch.ready) sb.note_command(cmd_ch.payload);
      if (rsp_ch.valid && rsp_ch.ready) sb.check_response(rsp_ch.payload);
    end
  end

  function automatic cmd_t make_command(logic [OP_W-1:0] op, logic [BYTE_W-1:0] data,
                                        logic parity, logic dre);
    cmd_t c;
    c.operation      = op;
    c.data_byte      = data;
    c.parity_error   = parity;
    c.data_reg_empty = dre;
    return c;
  endfunction

  // Pick a command; the mode weights the mix so that the rings reach full
  // during fill segments and empty again during drain segments.
  function automatic cmd_t random_command(traffic_mode_t mode);
    cmd_t c;
    int   pick;
    int   lim_rx;
    int   lim_rd;
    int   lim_wr;
    int   lim_dre;
    case (mode)
      FILL_RINGS: begin
        lim_rx = 45; lim_rd = 50; lim_wr = 93; lim_dre = 97;
      end
      DRAIN_RINGS: begin
        lim_rx = 10; lim_rd = 55; lim_wr = 65; lim_dre = 97;
      end
      default: begin
        lim_rx = 25; lim_rd = 50; lim_wr = 75; lim_dre = 96;
      end
    endcase
    c.data_byte      = BYTE_W'($urandom_range(0, 255));
    c.parity_error   = ($urandom_range(0, 7) == 0);
    c.data_reg_empty = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 99);
    if (pick < lim_rx)
      c.operation = OP_LINE_RX;
    else if (pick < lim_rd)
      c.operation = $urandom_range(0, 1) ? OP_READ : OP_PEEK;
    else if (pick < lim_wr)
      c.operation = OP_HOST_WR;
    else if (pick < lim_dre)
      c.operation = OP_DRE_EVT;
    else
      c.operation = OP_W'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
    return c;
  endfunction

  // Offer one command, optionally after an idle gap, and hold it until the
  // transfer. Valid stays high into the next call so back-to-back commands
  // need no dip.
  task automatic send_command(input cmd_t c);
    int gap;
    if ((items_sent / SEGMENT_ITEMS) % 3 == 1)
      gap = 0;
    else
      gap = $urandom_range(0, 7);
    if (gap > 0) begin
      cmd_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_ch.payload = c;
    cmd_ch.valid   = 1'b1;
    do @(posedge clk); while (!(cmd_ch.valid && cmd_ch.ready));
    items_sent++;
    @(negedge clk);
  endtask

  // Response side: stall a random number of cycles before each transfer,
  // run some stretches with no stalls, and once hold off long enough that
  // the output register fills and the block stops taking commands.
  initial begin : response_sink
    int stall;
    rsp_ch.ready = 1'b0;
    wait (!rst);
    forever begin
      if (results_taken == HOLD_AFTER)
        stall = HOLD_CYCLES;
      else if ((results_taken / 170) % 3 == 2)
        stall = 0;
      else
        stall = $urandom_range(0, 7);
      if (stall > 0) begin
        rsp_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_ch.ready = 1'b1;
      do @(posedge clk); while (!(rsp_ch.valid && rsp_ch.ready));
      results_taken++;
      @(negedge clk);
    end
  end

  initial begin : command_source
    cmd_t          directed [$];
    traffic_mode_t mode;
    sb             = new();
    cmd_ch.valid   = 1'b0;
    cmd_ch.payload = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Empty rings: peek, read and drain find nothing; drain flag stays off.
    directed.push_back(make_command(OP_PEEK,    8'h00, 1'b0, 1'b0));
    directed.push_back(make_command(OP_READ,    8'hFF, 1'b1, 1'b1));
    directed.push_back(make_command(OP_DRE_EVT, 8'h00, 1'b0, 1'b0));
    // Unused codes only report status.
    directed.push_back(make_command(OP_UNUSED_FIRST,            8'hAA, 1'b1, 1'b1));
    directed.push_back(make_command(OP_W'(OP_UNUSED_FIRST + 1), 8'h55, 1'b0, 1'b0));
    directed.push_back(make_command(OP_UNUSED_LAST,             8'hFF, 1'b1, 1'b0));
    // Receive extremes, then a byte with a parity error that must be dropped.
    directed.push_back(make_command(OP_LINE_RX, 8'h00, 1'b0, 1'b0));
    directed.push_back(make_command(OP_LINE_RX, 8'hFF, 1'b0, 1'b1));
    directed.push_back(make_command(OP_LINE_RX, 8'hA5, 1'b1, 1'b0));
    directed.push_back(make_command(OP_PEEK,    8'h00, 1'b0, 1'b0));
    directed.push_back(make_command(OP_READ,    8'h00, 1'b0, 1'b0));
    directed.push_back(make_command(OP_READ,    8'h00, 1'b0, 1'b0));
    directed.push_back(make_command(OP_READ,    8'h00, 1'b0, 1'b0));
    // Direct send, then queue behind a busy data register and drain.
    directed.push_back(make_command(OP_HOST_WR, 8'h00, 1'b0, 1'b1));
    directed.push_back(make_command(OP_HOST_WR, 8'hFF, 1'b1, 1'b0));
    directed.push_back(make_command(OP_HOST_WR, 8'h5A, 1'b0, 1'b1));
    directed.push_back(make_command(OP_DRE_EVT, 8'h00, 1'b0, 1'b0));
    directed.push_back(make_command(OP_DRE_EVT, 8'hFF, 1'b1, 1'b1));
    directed.push_back(make_command(OP_DRE_EVT, 8'h00, 1'b0, 1'b0));
    directed.push_back(make_command(OP_HOST_WR, 8'h81, 1'b0, 1'b0));
    directed.push_back(make_command(OP_DRE_EVT, 8'h00, 1'b0, 1'b1));
    directed.push_back(make_command(OP_LINE_RX, 8'h7E, 1'b1, 1'b1));
    foreach (directed[i]) send_command(directed[i]);

    // Two fill segments, a mixed one, two drain segments, a mixed one, repeat.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      case ((n / SEGMENT_ITEMS) % 6)
        0, 1:    mode = FILL_RINGS;
        3, 4:    mode = DRAIN_RINGS;
        default: mode = MIX_TRAFFIC;
      endcase
      send_command(random_command(mode));
    end
    cmd_ch.valid = 1'b0;

    // Drain outstanding responses, then give the pipeline time to misbehave.
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
